// ----- rtl/csq_pkg.sv -----
// Shared types and codes for the counting semaphore wait queue.
// Used by csq_cell, csq_ctrl and counting_semaphore_wait_queue; no dependencies.
package csq_pkg;

  localparam int ThreadIdW = 8;
  localparam int CountW    = 18;
  localparam int InitW     = 16;

  localparam logic [CountW-1:0] CountMax = 18'h1FFFF;

  // operation codes
  localparam logic [2:0] FUNC_WAIT       = 3'd0;
  localparam logic [2:0] FUNC_SIGNAL     = 3'd1;
  localparam logic [2:0] FUNC_TRY_WAIT   = 3'd2;
  localparam logic [2:0] FUNC_TIMED_WAIT = 3'd3;
  localparam logic [2:0] FUNC_TIMEOUT    = 3'd4;
  localparam logic [2:0] FUNC_CLOSE      = 3'd5;

  // result status codes
  localparam logic [2:0] STAT_ACQUIRED   = 3'd0;
  localparam logic [2:0] STAT_BLOCKED    = 3'd1;
  localparam logic [2:0] STAT_UNAVAIL    = 3'd2;
  localparam logic [2:0] STAT_TIMED_OUT  = 3'd3;
  localparam logic [2:0] STAT_NO_WAITER  = 3'd4;
  localparam logic [2:0] STAT_CLOSED     = 3'd5;
  localparam logic [2:0] STAT_QUEUE_FULL = 3'd6;

  typedef struct packed {
    logic [2:0]           func;
    logic [ThreadIdW-1:0] thread_id;
    logic                 timeout_nonzero;
  } csq_in_t;

  typedef struct packed {
    logic [2:0]           status;
    logic                 woken_valid;
    logic [ThreadIdW-1:0] woken_thread;
    logic                 woken_forced;
    logic                 last;
  } csq_out_t;

  // queue commands broadcast to every cell
  typedef struct packed {
    logic push;    // write key into the cell at the tail
    logic shift;   // every cell takes its right neighbor (pop head)
    logic remove;  // cells at and after the oldest match take their right neighbor
  } cell_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DRAIN
  } state_t;

endpackage

// ----- rtl/counting_semaphore_wait_queue.sv -----
// Top level of the counting semaphore with a FIFO wait queue.
// Builds the row of csq_cell slots and the csq_ctrl sequencer; depends on csq_pkg.
//
//  channel | ports                          | payload
//  --------+--------------------------------+----------------------------
//  in      | in_valid / in_ready / in_data  | csq_in_t: func, id, timeout
//  out     | out_valid / out_ready/out_data | csq_out_t: status, woken, last
//  cfg     | cfg_valid / cfg_ready/cfg_data | initial_count, 16 bits
//
// An item is accepted in ST_IDLE and then executed in ST_EXEC, in which the
// cell row matches, pushes, pops or compacts. A close with N waiters then drains
// one forced result per cycle while out_ready allows. A stalled out_ready holds
// execute and drain; the next item is still taken while a result waits.
// Reset is synchronous: count and the waiter total clear, no clearing pass.
module counting_semaphore_wait_queue #(
  parameter int MAX_WAITERS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  csq_pkg::csq_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output csq_pkg::csq_out_t         out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [csq_pkg::InitW-1:0] cfg_data
);

  localparam int TotW = $clog2(MAX_WAITERS + 1);

  csq_pkg::cell_cmd_t            cmd;
  logic [csq_pkg::ThreadIdW-1:0] key;
  logic [TotW-1:0]               total;
  logic [csq_pkg::ThreadIdW-1:0] ids  [MAX_WAITERS+1];
  logic                          hits [MAX_WAITERS+1];

  assign ids[MAX_WAITERS] = '0;
  assign hits[0]          = 1'b0;

  for (genvar i = 0; i < MAX_WAITERS; i++) begin : g_cell
    csq_cell #(
      .MAX_WAITERS(MAX_WAITERS),
      .IDX        (i)
    ) u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .key     (key),
      .total   (total),
      .id_right(ids[i+1]),
      .hit_in  (hits[i]),
      .id_out  (ids[i]),
      .hit_out (hits[i+1])
    );
  end

  csq_ctrl #(
    .MAX_WAITERS(MAX_WAITERS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .key      (key),
    .total    (total),
    .head_id  (ids[0]),
    .hit_all  (hits[MAX_WAITERS])
  );

endmodule

// ----- rtl/csq_cell.sv -----
// One slot of the waiter queue: holds a thread id and compacts toward the head.
// Depends on csq_pkg.
module csq_cell #(
  parameter int MAX_WAITERS = 16,
  parameter int IDX         = 0
) (
  input  logic                            clk,
  input  csq_pkg::cell_cmd_t              cmd,
  input  logic [csq_pkg::ThreadIdW-1:0]   key,
  input  logic [$clog2(MAX_WAITERS+1)-1:0] total,
  input  logic [csq_pkg::ThreadIdW-1:0]   id_right,
  input  logic                            hit_in,
  output logic [csq_pkg::ThreadIdW-1:0]   id_out,
  output logic                            hit_out
);

  localparam int TotW = $clog2(MAX_WAITERS + 1);

  logic [csq_pkg::ThreadIdW-1:0] id_r;
  logic [csq_pkg::ThreadIdW-1:0] id_nxt;
  logic                          occupied;
  logic                          match;
  logic                          take_right;

  assign occupied   = total > TotW'(IDX);
  assign match      = occupied && (id_r == key);
  assign hit_out    = hit_in | match;
  assign take_right = cmd.shift || (cmd.remove && (hit_in || match));

  always_comb begin
    id_nxt = id_r;
    if (take_right) begin
      id_nxt = id_right;
    end else if (cmd.push && (total == TotW'(IDX))) begin
      id_nxt = key;
    end
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt;
  end

  assign id_out = id_r;

endmodule

// ----- rtl/csq_ctrl.sv -----
// Sequencer for the semaphore: count, waiter total, item and result registers.
// Drives queue commands to the cell row. Depends on csq_pkg.
module csq_ctrl #(
  parameter int MAX_WAITERS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  csq_pkg::csq_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output csq_pkg::csq_out_t                out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [csq_pkg::InitW-1:0]        cfg_data,
  output csq_pkg::cell_cmd_t               cmd,
  output logic [csq_pkg::ThreadIdW-1:0]    key,
  output logic [$clog2(MAX_WAITERS+1)-1:0] total,
  input  logic [csq_pkg::ThreadIdW-1:0]    head_id,
  input  logic                             hit_all
);

  localparam int TotW = $clog2(MAX_WAITERS + 1);
  localparam int CW   = csq_pkg::CountW;

  csq_pkg::state_t            state_r, state_nxt;
  csq_pkg::csq_in_t           item_r;
  logic [CW-1:0]              count_r, count_nxt;
  logic [TotW-1:0]            total_r, total_nxt;
  logic [csq_pkg::InitW-1:0]  init_r;
  logic                       out_valid_r;
  csq_pkg::csq_out_t          out_data_r;
  csq_pkg::csq_out_t          res;
  logic                       load_out;
  logic                       space;
  logic                       cnt_pos;
  logic                       cnt_neg;
  logic                       full;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == csq_pkg::ST_IDLE);
  assign space     = !out_valid_r || out_ready;
  assign cnt_neg   = count_r[CW-1];
  assign cnt_pos   = !cnt_neg && (count_r != '0);
  assign full      = (total_r == TotW'(MAX_WAITERS));
  assign key       = item_r.thread_id;
  assign total     = total_r;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    total_nxt = total_r;
    cmd       = '0;
    res       = '0;
    res.last  = 1'b1;
    load_out  = 1'b0;
    unique case (state_r)
      csq_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = csq_pkg::ST_EXEC;
        end
      end
      csq_pkg::ST_EXEC: begin
        if (space) begin
          load_out  = 1'b1;
          state_nxt = csq_pkg::ST_IDLE;
          case (item_r.func) inside
            csq_pkg::FUNC_WAIT, csq_pkg::FUNC_TIMED_WAIT: begin
              if ((item_r.func == csq_pkg::FUNC_TIMED_WAIT) && !cnt_pos
                  && !item_r.timeout_nonzero) begin
                res.status = csq_pkg::STAT_TIMED_OUT;
              end else if (cnt_pos) begin
                count_nxt  = count_r - CW'(1);
                res.status = csq_pkg::STAT_ACQUIRED;
              end else if (full) begin
                res.status = csq_pkg::STAT_QUEUE_FULL;
              end else begin
                count_nxt  = count_r - CW'(1);
                total_nxt  = total_r + TotW'(1);
                cmd.push   = 1'b1;
                res.status = csq_pkg::STAT_BLOCKED;
              end
            end
            csq_pkg::FUNC_SIGNAL: begin
              res.status = csq_pkg::STAT_ACQUIRED;
              if (count_r != csq_pkg::CountMax) begin
                count_nxt = count_r + CW'(1);
                // count stays at or below zero: release the head
                if (cnt_neg) begin
                  if (total_r == '0) begin
                    res.status = csq_pkg::STAT_NO_WAITER;
                  end else begin
                    cmd.shift        = 1'b1;
                    total_nxt        = total_r - TotW'(1);
                    res.woken_valid  = 1'b1;
                    res.woken_thread = head_id;
                  end
                end
              end
            end
            csq_pkg::FUNC_TRY_WAIT: begin
              if (cnt_pos) begin
                count_nxt  = count_r - CW'(1);
                res.status = csq_pkg::STAT_ACQUIRED;
              end else begin
                res.status = csq_pkg::STAT_UNAVAIL;
              end
            end
            csq_pkg::FUNC_TIMEOUT: begin
              if (hit_all) begin
                cmd.remove       = 1'b1;
                total_nxt        = total_r - TotW'(1);
                count_nxt        = count_r + CW'(1);
                res.status       = csq_pkg::STAT_TIMED_OUT;
                res.woken_valid  = 1'b1;
                res.woken_thread = item_r.thread_id;
              end else begin
                res.status = csq_pkg::STAT_NO_WAITER;
              end
            end
            csq_pkg::FUNC_CLOSE: begin
              count_nxt  = {{(CW - csq_pkg::InitW){1'b0}}, init_r};
              res.status = csq_pkg::STAT_CLOSED;
              if (total_r != '0) begin
                // hand the waiters out one per cycle while the output has space
                load_out  = 1'b0;
                state_nxt = csq_pkg::ST_DRAIN;
              end
            end
            default: begin
              res.status = csq_pkg::STAT_NO_WAITER;
            end
          endcase
        end
      end
      csq_pkg::ST_DRAIN: begin
        if (space) begin
          load_out         = 1'b1;
          cmd.shift        = 1'b1;
          total_nxt        = total_r - TotW'(1);
          res.status       = csq_pkg::STAT_CLOSED;
          res.woken_valid  = 1'b1;
          res.woken_thread = head_id;
          res.woken_forced = 1'b1;
          res.last         = (total_r == TotW'(1));
          if (total_r == TotW'(1)) begin
            state_nxt = csq_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = csq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= csq_pkg::ST_IDLE;
      count_r     <= '0;
      total_r     <= '0;
      init_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      total_r <= total_nxt;
      if (cfg_valid) begin
        init_r <= cfg_data;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    if (load_out) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// Testbench for counting_semaphore_wait_queue: directed and random semaphore traffic,
// each reply checked against an in-bench model of the count and the wait line.
// Depends on csq_pkg and the RTL top level only.
module tb;

  localparam int MaxWaiters = 16;
  localparam int CountTop   = int'(csq_pkg::CountMax);

  // func values the block must ignore
  localparam logic [2:0] FUNC_RSVD6 = 3'd6;
  localparam logic [2:0] FUNC_RSVD7 = 3'd7;

  logic                      clk;
  logic                      rst_n     = 1'b0;
  logic                      in_valid  = 1'b0;
  logic                      in_ready;
  csq_pkg::csq_in_t          in_data   = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  csq_pkg::csq_out_t         out_data;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [csq_pkg::InitW-1:0] cfg_data  = '0;

  counting_semaphore_wait_queue #(.MAX_WAITERS(MaxWaiters)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // semaphore model
  logic [csq_pkg::InitW-1:0]     init_count_reg = '0;
  int                            sem_count      = 0;
  logic [csq_pkg::ThreadIdW-1:0] wait_line[$];
  csq_pkg::csq_out_t             pending_replies[$];

  int err_count   = 0;
  int item_count  = 0;
  int reply_count = 0;

  // traffic shaping
  int burst_left  = 0;
  bit src_gaps    = 1'b1;
  bit sink_stalls = 1'b1;
  int hold_req    = 0;
  int hold_left   = 0;
  int sink_run    = 0;
  bit sink_phase  = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(2_000_000);
    $display("tb: errors");
    $finish;
  end

  function automatic logic [2:0] take_or_queue(input logic [csq_pkg::ThreadIdW-1:0] id);
    if (sem_count - 1 < 0) begin
      if (wait_line.size() >= MaxWaiters) return csq_pkg::STAT_QUEUE_FULL;
      sem_count--;
      wait_line.push_back(id);
      return csq_pkg::STAT_BLOCKED;
    end
    sem_count--;
    return csq_pkg::STAT_ACQUIRED;
  endfunction

  // Advance the model by one operation and queue the replies it owes.
  function automatic void sem_step(input csq_pkg::csq_in_t op);
    csq_pkg::csq_out_t r;
    int                hit;
    int                n;
    r = '0;
    r.last = 1'b1;
    case (op.func)
      csq_pkg::FUNC_WAIT: r.status = take_or_queue(op.thread_id);
      csq_pkg::FUNC_SIGNAL: begin
        r.status = csq_pkg::STAT_ACQUIRED;
        if (sem_count < CountTop) begin
          sem_count++;
          if (sem_count <= 0) begin
            if (wait_line.size() == 0) begin
              r.status = csq_pkg::STAT_NO_WAITER;
            end else begin
              r.woken_valid  = 1'b1;
              r.woken_thread = wait_line.pop_front();
            end
          end
        end
      end
      csq_pkg::FUNC_TRY_WAIT: begin
        if (sem_count > 0) begin
          sem_count--;
          r.status = csq_pkg::STAT_ACQUIRED;
        end else begin
          r.status = csq_pkg::STAT_UNAVAIL;
        end
      end
      csq_pkg::FUNC_TIMED_WAIT: begin
        if (sem_count <= 0 && !op.timeout_nonzero) r.status = csq_pkg::STAT_TIMED_OUT;
        else r.status = take_or_queue(op.thread_id);
      end
      csq_pkg::FUNC_TIMEOUT: begin
        hit = -1;
        for (int i = 0; i < wait_line.size(); i++) begin
          if (hit < 0 && wait_line[i] == op.thread_id) hit = i;
        end
        if (hit >= 0) begin
          wait_line.delete(hit);
          sem_count++;
          r.status       = csq_pkg::STAT_TIMED_OUT;
          r.woken_valid  = 1'b1;
          r.woken_thread = op.thread_id;
        end else begin
          r.status = csq_pkg::STAT_NO_WAITER;
        end
      end
      csq_pkg::FUNC_CLOSE: begin
        sem_count = int'(init_count_reg);
        n = wait_line.size();
        r.status = csq_pkg::STAT_CLOSED;
        if (n == 0) begin
          pending_replies.push_back(r);
        end else begin
          // one forced release per waiter, oldest first
          for (int i = 0; i < n; i++) begin
            r.woken_valid  = 1'b1;
            r.woken_thread = wait_line[i];
            r.woken_forced = 1'b1;
            r.last         = (i == n - 1);
            pending_replies.push_back(r);
          end
          wait_line.delete();
        end
        return;
      end
      default: r.status = csq_pkg::STAT_NO_WAITER;
    endcase
    pending_replies.push_back(r);
  endfunction

  function automatic csq_pkg::csq_in_t mk_op(input logic [2:0] func, input logic [7:0] id,
                                             input logic tnz);
    csq_pkg::csq_in_t op;
    op.func            = func;
    op.thread_id       = id;
    op.timeout_nonzero = tnz;
    return op;
  endfunction

  function automatic csq_pkg::csq_in_t rand_op();
    csq_pkg::csq_in_t op;
    int               pick;
    op.thread_id       = 8'($urandom);
    op.timeout_nonzero = 1'($urandom);
    // a narrow id range now and then so duplicates get queued
    if ($urandom_range(0, 3) == 0) op.thread_id = 8'($urandom_range(0, 7));
    pick = $urandom_range(0, 99);
    if (pick < 34) op.func = csq_pkg::FUNC_WAIT;
    else if (pick < 56) op.func = csq_pkg::FUNC_SIGNAL;
    else if (pick < 66) op.func = csq_pkg::FUNC_TRY_WAIT;
    else if (pick < 78) op.func = csq_pkg::FUNC_TIMED_WAIT;
    else if (pick < 93) begin
      op.func = csq_pkg::FUNC_TIMEOUT;
      if (wait_line.size() != 0 && $urandom_range(0, 3) != 0)
        op.thread_id = wait_line[$urandom_range(0, wait_line.size() - 1)];
    end
    else if (pick < 97) op.func = csq_pkg::FUNC_CLOSE;
    else op.func = $urandom_range(0, 1) ? FUNC_RSVD6 : FUNC_RSVD7;
    return op;
  endfunction

  task automatic send_op(input csq_pkg::csq_in_t op);
    int gap;
    if (src_gaps && burst_left == 0) begin
      gap = $urandom_range(0, 7);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    in_data  <= op;
    do @(posedge clk); while (!in_ready);
    sem_step(op);
    item_count++;
  endtask

  // Drop valid and wait for every owed reply.
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_replies.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_init(input logic [csq_pkg::InitW-1:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    init_count_reg = value;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cmp_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      err_count++;
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endtask

  // receiver: long hold-off on request, else alternating ready/stall runs
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (hold_req > 0) begin
      hold_left = hold_req - 1;
      hold_req  = 0;
      out_ready <= 1'b0;
    end else if (!sink_stalls) begin
      out_ready <= 1'b1;
    end else begin
      if (sink_run == 0) begin
        sink_phase = !sink_phase;
        sink_run   = sink_phase ? $urandom_range(1, 9) : $urandom_range(1, 4);
      end
      sink_run--;
      out_ready <= sink_phase;
    end
  end

  always @(posedge clk) begin
    csq_pkg::csq_out_t want;
    if (rst_n && out_valid && out_ready) begin
      reply_count++;
      if (pending_replies.size() == 0) begin
        err_count++;
        $display("%0t: reply expected none got %p", $time, out_data);
      end else begin
        want = pending_replies.pop_front();
        cmp_field("status", 8'(want.status), 8'(out_data.status));
        cmp_field("woken_valid", 8'(want.woken_valid), 8'(out_data.woken_valid));
        cmp_field("woken_thread", want.woken_thread, out_data.woken_thread);
        cmp_field("woken_forced", 8'(want.woken_forced), 8'(out_data.woken_forced));
        cmp_field("last", 8'(want.last), 8'(out_data.last));
      end
    end
  end

  // Operations on an empty line straight after reset, count at zero.
  task automatic test_idle_ops();
    send_op(mk_op(csq_pkg::FUNC_TRY_WAIT, 8'h01, 1'b0));
    send_op(mk_op(csq_pkg::FUNC_TIMED_WAIT, 8'h02, 1'b0));
    send_op(mk_op(csq_pkg::FUNC_SIGNAL, 8'h03, 1'b1));
    send_op(mk_op(csq_pkg::FUNC_TRY_WAIT, 8'h04, 1'b1));
    send_op(mk_op(csq_pkg::FUNC_TIMEOUT, 8'hFF, 1'b0));
    send_op(mk_op(csq_pkg::FUNC_CLOSE, 8'h00, 1'b0));
    send_op(mk_op(FUNC_RSVD6, 8'hA5, 1'b1));
    send_op(mk_op(FUNC_RSVD7, 8'h5A, 1'b0));
  endtask

  // Block, remove from the middle, wake, fill to the limit, then close.
  task automatic test_wait_line();
    send_op(mk_op(csq_pkg::FUNC_WAIT, 8'h00, 1'b0));
    send_op(mk_op(csq_pkg::FUNC_WAIT, 8'hFF, 1'b1));
    send_op(mk_op(csq_pkg::FUNC_WAIT, 8'h55, 1'b0));
    send_op(mk_op(csq_pkg::FUNC_WAIT, 8'h55, 1'b0));
    send_op(mk_op(csq_pkg::FUNC_TIMED_WAIT, 8'hAA, 1'b1));
    send_op(mk_op(csq_pkg::FUNC_TIMEOUT, 8'h55, 1'b0));
    send_op(mk_op(csq_pkg::FUNC_TIMEOUT, 8'h12, 1'b0));
    send_op(mk_op(csq_pkg::FUNC_SIGNAL, 8'h00, 1'b0));
    while (wait_line.size() < MaxWaiters)
      send_op(mk_op(csq_pkg::FUNC_WAIT, 8'($urandom), 1'($urandom)));
    send_op(mk_op(csq_pkg::FUNC_WAIT, 8'h77, 1'b0));
    send_op(mk_op(csq_pkg::FUNC_TIMED_WAIT, 8'h78, 1'b1));
    send_op(mk_op(csq_pkg::FUNC_TIMED_WAIT, 8'h79, 1'b0));
    send_op(mk_op(csq_pkg::FUNC_TIMEOUT, wait_line[MaxWaiters - 1], 1'b0));
    send_op(mk_op(csq_pkg::FUNC_CLOSE, 8'h00, 1'b0));
  endtask

  // Top initial count, then signal above it and take units back.
  task automatic test_large_count();
    load_init({csq_pkg::InitW{1'b1}});
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    send_op(mk_op(csq_pkg::FUNC_CLOSE, 8'h00, 1'b0));
    repeat (3) send_op(mk_op(csq_pkg::FUNC_SIGNAL, 8'($urandom), 1'($urandom)));
    send_op(mk_op(csq_pkg::FUNC_TRY_WAIT, 8'h00, 1'b0));
    send_op(mk_op(csq_pkg::FUNC_WAIT, 8'h01, 1'b0));
    send_op(mk_op(csq_pkg::FUNC_TIMED_WAIT, 8'h02, 1'b0));
    send_op(mk_op(csq_pkg::FUNC_SIGNAL, 8'h00, 1'b0));
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    load_init('0);
    send_op(mk_op(csq_pkg::FUNC_CLOSE, 8'h00, 1'b0));
  endtask

  // Hold the output off while items keep coming, then pause until drained.
  task automatic test_backpressure();
    settle();
    src_gaps = 1'b0;
    hold_req = 40;
    for (int i = 0; i < 12; i++) send_op(rand_op());
    src_gaps = 1'b1;
    settle();
  endtask

  task automatic test_random();
    logic [csq_pkg::InitW-1:0] inits[4];
    inits[0] = '0;
    inits[1] = 16'd1;
    inits[2] = {csq_pkg::InitW{1'b1}};
    inits[3] = 16'($urandom_range(2, 65534));
    for (int p = 0; p < 4; p++) begin
      load_init(inits[p]);
      src_gaps    = !p[0];
      sink_stalls = (p != 1) && (p != 2);
      send_op(mk_op(csq_pkg::FUNC_CLOSE, 8'($urandom), 1'($urandom)));
      for (int i = 0; i < 15; i++) send_op(rand_op());
    end
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_ops();
    test_wait_line();
    test_large_count();
    test_backpressure();
    test_random();
    settle();
    repeat (10) @(posedge clk);
    $display("tb summary: %0d transactions sent, %0d replies checked", item_count, reply_count);
    $display("tb summary: idle ops, full wait line, large count, output hold-off, 4 init phases");
    if (err_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
